### design/quantized_sine_cosine_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quantized sine/cosine table
// Shared helpers for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef QUANTIZED_SINE_COSINE_TABLE_MACROS_SVH
`define QUANTIZED_SINE_COSINE_TABLE_MACROS_SVH

// same-cycle implication, masked during reset
`define QSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsc check failed");

// next-cycle implication, masked during reset
`define QSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsc check failed");

// next-cycle implication, also checked through reset
`define QSC_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qsc check failed");

`endif

### design/qsc_pkg.sv
// ---------------------------------------------------------------------------
// qsc_pkg
// Shared types, constants and tables of the quantized sine/cosine table.
// ---------------------------------------------------------------------------
package qsc_pkg;

  localparam int DEF_INDEX_BITS         = 16;
  localparam int DEF_MAX_AMPLITUDE_BITS = 24;
  localparam int DEF_CORDIC_STAGES      = 28;

  localparam int PHASE_W  = 32;
  localparam int FRAC_W   = 30;
  localparam int CORDIC_W = 34;
  localparam int MAG_W    = 32;
  localparam int OUT_W    = 24;
  localparam int COUNT_W  = 16;
  localparam int AMP_W    = 5;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-1:0]  REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [ADDR_W-1:0]  REG_AMPLITUDE_BITS = 3'd4;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST   = 16'd256;
  localparam logic [AMP_W-1:0]   AMPLITUDE_BITS_RST = 5'd16;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  // atan(2^-k), 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic valid;
    logic err;
  } qsc_tag_t;

endpackage

### design/qsc_phase_div.sv
// ---------------------------------------------------------------------------
// qsc_phase_div
// Pipelined restoring divider: phase = round(index * 2^32 / count),
// one quotient bit per stage.
// ---------------------------------------------------------------------------
module qsc_phase_div import qsc_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  qsc_tag_t              in_tag,
  input  logic [INDEX_BITS-1:0] idx,
  input  logic [INDEX_BITS-1:0] n,
  output qsc_tag_t              out_tag,
  output logic [PHASE_W-1:0]    phase
);

  logic [PHASE_W-1:0]    half;
  qsc_tag_t              tag [PHASE_W+1];
  logic [INDEX_BITS-1:0] rem [PHASE_W+1];
  logic [PHASE_W-1:0]    quo [PHASE_W+1];

  assign half   = PHASE_W'(n >> 1);
  assign tag[0] = in_tag;
  assign rem[0] = idx;
  assign quo[0] = '0;

  for (genvar j = 0; j < PHASE_W; j++) begin : g_stage
    logic [INDEX_BITS:0]   trial;
    logic                  ge;
    logic [INDEX_BITS-1:0] rem_next;

    always_comb begin
      trial    = {rem[j], half[PHASE_W-1-j]};
      ge       = trial >= {1'b0, n};
      rem_next = ge ? INDEX_BITS'(trial - {1'b0, n}) : INDEX_BITS'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[j+1] <= '0;
      end else if (en) begin
        tag[j+1] <= tag[j];
      end
      if (en) begin
        rem[j+1] <= rem_next;
        quo[j+1] <= {quo[j][PHASE_W-2:0], ge};
      end
    end
  end

  assign out_tag = tag[PHASE_W];
  assign phase   = quo[PHASE_W];

endmodule

### design/qsc_cordic.sv
// ---------------------------------------------------------------------------
// qsc_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ---------------------------------------------------------------------------
module qsc_cordic import qsc_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  qsc_tag_t                   in_tag,
  input  logic [1:0]                 in_quad,
  input  logic [FRAC_W-1:0]          angle,
  output qsc_tag_t                   out_tag,
  output logic [1:0]                 out_quad,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out
);

  qsc_tag_t                   tag  [CORDIC_STAGES+1];
  logic [1:0]                 quad [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] x    [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] y    [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] z    [CORDIC_STAGES+1];

  assign tag[0]  = in_tag;
  assign quad[0] = in_quad;
  assign x[0]    = CORDIC_W'(CORDIC_GAIN_Q30);
  assign y[0]    = '0;
  assign z[0]    = CORDIC_W'(angle);

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] at;

    always_comb begin
      xs = x[k] >>> k;
      ys = y[k] >>> k;
      at = CORDIC_W'(ATAN_TAB[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k+1] <= '0;
      end else if (en) begin
        tag[k+1] <= tag[k];
      end
      if (en) begin
        quad[k+1] <= quad[k];
        if (!z[k][CORDIC_W-1]) begin
          x[k+1] <= x[k] - ys;
          y[k+1] <= y[k] + xs;
          z[k+1] <= z[k] - at;
        end else begin
          x[k+1] <= x[k] + ys;
          y[k+1] <= y[k] - xs;
          z[k+1] <= z[k] + at;
        end
      end
    end
  end

  assign out_tag  = tag[CORDIC_STAGES];
  assign out_quad = quad[CORDIC_STAGES];
  assign x_out    = x[CORDIC_STAGES];
  assign y_out    = y[CORDIC_STAGES];

endmodule

### design/quantized_sine_cosine_table.sv
// ---------------------------------------------------------------------------
// quantized_sine_cosine_table
// Scaled, rounded sine and cosine of 2*pi*i/N for a stream of sample indexes.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata: sample_index
//   m_*      out  tvalid/tready      tdata: sine, cosine; tuser: index_error
//   apb      in   psel/penable/pready  sample_count @0, amplitude_bits @4
//
// One transfer per cycle in and out unless the output stalls. The pipe has
// 32 divider stages for the phase, one stage per CORDIC rotation, then quadrant
// map, magnitude, multiply and round. rst clears the valid bits and sets the
// registers to N = 256, 16 bits. A stall on m_tready freezes the whole pipe.
// ---------------------------------------------------------------------------
module quantized_sine_cosine_table import qsc_pkg::*; #(
  parameter int INDEX_BITS         = DEF_INDEX_BITS,
  parameter int MAX_AMPLITUDE_BITS = DEF_MAX_AMPLITUDE_BITS,
  parameter int CORDIC_STAGES      = DEF_CORDIC_STAGES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((INDEX_BITS+7)/8)*8-1:0]     s_tdata,   // [INDEX_BITS-1:0] sample_index
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*OUT_W-1:0]                  m_tdata,   // sine_value, cosine_value
  output logic                                m_tuser,   // index_error
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ADDR_W-1:0]                   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int FACT_W = MAX_AMPLITUDE_BITS - 1;
  localparam int PROD_W = MAG_W + FACT_W;
  localparam int RND_W  = PROD_W + 1 - FRAC_W;
  localparam int ABC_W  = $clog2(MAX_AMPLITUDE_BITS + 1);

  logic [COUNT_W-1:0] sample_count;
  logic [AMP_W-1:0]   amplitude_bits;

  logic                  en;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] n;
  qsc_tag_t              in_tag;
  logic [ABC_W-1:0]      ab;
  logic [FACT_W-1:0]     factor;

  qsc_tag_t                   div_tag;
  logic [PHASE_W-1:0]         phase;
  qsc_tag_t                   cor_tag;
  logic [1:0]                 cor_quad;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;

  qsc_tag_t                   map_tag;
  logic signed [CORDIC_W-1:0] c_map;
  logic signed [CORDIC_W-1:0] s_map;
  qsc_tag_t                   mag_tag;
  logic [MAG_W-1:0]           c_mag;
  logic [MAG_W-1:0]           s_mag;
  logic                       c_neg;
  logic                       s_neg;
  qsc_tag_t                   mul_tag;
  logic [PROD_W-1:0]          c_prod;
  logic [PROD_W-1:0]          s_prod;
  logic                       c_neg_m;
  logic                       s_neg_m;

  logic [RND_W-1:0]  c_rnd;
  logic [RND_W-1:0]  s_rnd;
  logic [FACT_W-1:0] c_sat;
  logic [FACT_W-1:0] s_sat;
  logic [OUT_W-1:0]  c_res;
  logic [OUT_W-1:0]  s_res;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= SAMPLE_COUNT_RST;
      amplitude_bits <= AMPLITUDE_BITS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SAMPLE_COUNT[2]:   sample_count   <= pwdata[COUNT_W-1:0];
        REG_AMPLITUDE_BITS[2]: amplitude_bits <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SAMPLE_COUNT[2]:   prdata = 32'(sample_count);
      REG_AMPLITUDE_BITS[2]: prdata = 32'(amplitude_bits);
      default:               prdata = '0;
    endcase
  end

  // input side
  assign en     = !m_tvalid || m_tready;
  assign s_tready = en;
  assign idx    = s_tdata[INDEX_BITS-1:0];
  assign n      = INDEX_BITS'(sample_count);

  always_comb begin
    in_tag.valid = s_tvalid;
    in_tag.err   = idx >= n;
    if (amplitude_bits == '0) begin
      ab = ABC_W'(1);
    end else if (32'(amplitude_bits) > 32'(MAX_AMPLITUDE_BITS)) begin
      ab = ABC_W'(MAX_AMPLITUDE_BITS);
    end else begin
      ab = ABC_W'(amplitude_bits);
    end
    factor = FACT_W'((64'd1 << (ab - ABC_W'(1))) - 64'd1);
  end

  qsc_phase_div #(.INDEX_BITS(INDEX_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_tag  (in_tag),
    .idx     (idx),
    .n       (n),
    .out_tag (div_tag),
    .phase   (phase)
  );

  qsc_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (div_tag),
    .in_quad  (phase[PHASE_W-1:FRAC_W]),
    .angle    (phase[FRAC_W-1:0]),
    .out_tag  (cor_tag),
    .out_quad (cor_quad),
    .x_out    (cx),
    .y_out    (cy)
  );

  // quadrant map, magnitude, multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      map_tag <= '0;
      mag_tag <= '0;
      mul_tag <= '0;
    end else if (en) begin
      map_tag <= cor_tag;
      mag_tag <= map_tag;
      mul_tag <= mag_tag;
    end
    if (en) begin
      case (cor_quad)
        2'd0: begin c_map <= cx;  s_map <= cy;  end
        2'd1: begin c_map <= -cy; s_map <= cx;  end
        2'd2: begin c_map <= -cx; s_map <= -cy; end
        default: begin c_map <= cy; s_map <= -cx; end
      endcase
      c_neg   <= c_map[CORDIC_W-1];
      s_neg   <= s_map[CORDIC_W-1];
      c_mag   <= MAG_W'(c_map[CORDIC_W-1] ? -c_map : c_map);
      s_mag   <= MAG_W'(s_map[CORDIC_W-1] ? -s_map : s_map);
      c_neg_m <= c_neg;
      s_neg_m <= s_neg;
      c_prod  <= PROD_W'(c_mag) * PROD_W'(factor);
      s_prod  <= PROD_W'(s_mag) * PROD_W'(factor);
    end
  end

  // round half away, saturate, restore sign
  always_comb begin
    c_rnd = RND_W'(({1'b0, c_prod} + (RND_W + FRAC_W)'(1 << (FRAC_W - 1))) >> FRAC_W);
    s_rnd = RND_W'(({1'b0, s_prod} + (RND_W + FRAC_W)'(1 << (FRAC_W - 1))) >> FRAC_W);
    c_sat = (c_rnd > RND_W'(factor)) ? factor : FACT_W'(c_rnd);
    s_sat = (s_rnd > RND_W'(factor)) ? factor : FACT_W'(s_rnd);
    c_res = c_neg_m ? OUT_W'(0) - OUT_W'(c_sat) : OUT_W'(c_sat);
    s_res = s_neg_m ? OUT_W'(0) - OUT_W'(s_sat) : OUT_W'(s_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= mul_tag.valid;
    end
    if (en) begin
      m_tuser <= mul_tag.err;
      m_tdata <= mul_tag.err ? '0 : {c_res, s_res};
    end
  end

endmodule

### design/qsc_checker.sv
// ---------------------------------------------------------------------------
// qsc_checker
// Port-level checks of the quantized sine/cosine table, bound to the top.
// ---------------------------------------------------------------------------
`include "quantized_sine_cosine_table_macros.svh"

module qsc_checker import qsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [2*OUT_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               pready
);

  `QSC_ASSERT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid)
  `QSC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `QSC_ASSERT_NOW(a_err_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `QSC_ASSERT_NOW(a_flow, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready) && pready)

endmodule

bind quantized_sine_cosine_table qsc_checker u_qsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);

### bench/quantized_sine_cosine_table_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quantized_sine_cosine_table_test
// Streams sample indexes through the sine/cosine table under several period
// and amplitude settings, with random gaps on both sides, and compares every
// output transfer against a bit-exact CORDIC predictor kept in the bench or a known result.
// ---------------------------------------------------------------------------
module quantized_sine_cosine_table_test;
  import qsc_pkg::*;

  localparam int LATENCY   = 32 + DEF_CORDIC_STAGES + 4;
  localparam int MAX_CYCLE = 2000000;

  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
    logic                    index_err;
  } trig_t;

  typedef struct {
    logic [15:0] index;
    logic        known;
    trig_t       result;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // [15:0] sample_index
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [2*OUT_W-1:0] m_tdata;       // [23:0] sine_value, [47:24] cosine_value
  logic              m_tuser;        // [0] index_error
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  quantized_sine_cosine_table u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  logic [15:0] period_cfg;
  logic [4:0]  amp_cfg;
  trig_t       pending_trig[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycle = 0;
  bit          long_hold = 1'b0;

  function automatic logic [63:0] mag_round(logic [63:0] v, logic [63:0] peak);
    logic        neg;
    logic [63:0] m, r;
    neg = v[63];
    m = neg ? -v : v;
    r = (m * peak + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
    if (r > peak) r = peak;
    return neg ? -r : r;
  endfunction

  function automatic trig_t sine_cosine(logic [15:0] idx);
    trig_t       t;
    logic [63:0] n, ab, peak, phase, x, y, z, xs, ys, c, s;
    logic [1:0]  quad;
    t = '0;
    n = {48'd0, period_cfg};
    if ({48'd0, idx} >= n) begin
      t.index_err = 1'b1;
      return t;
    end
    ab = {59'd0, amp_cfg};
    if (ab < 1) ab = 1;
    if (ab > DEF_MAX_AMPLITUDE_BITS) ab = DEF_MAX_AMPLITUDE_BITS;
    peak = (64'd1 << (ab - 1)) - 1;
    phase = ((({48'd0, idx}) << 32) + (n >> 1)) / n;
    phase = phase & 64'hFFFF_FFFF;
    quad = phase[31:30];
    z = phase & 64'h3FFF_FFFF;
    x = {32'd0, CORDIC_GAIN_Q30};
    y = '0;
    for (int k = 0; k < DEF_CORDIC_STAGES; k++) begin
      xs = $signed(x) >>> k;
      ys = $signed(y) >>> k;
      if (!z[63]) begin
        x = x - ys; y = y + xs; z = z - {32'd0, ATAN_TAB[k]};
      end else begin
        x = x + ys; y = y - xs; z = z + {32'd0, ATAN_TAB[k]};
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    t.sine = OUT_W'(mag_round(s, peak));
    t.cosine = OUT_W'(mag_round(c, peak));
    return t;
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sink: random stalls, plus one long hold-off
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (long_hold) begin
          m_tready <= 1'b0;
          repeat (300) @(posedge clk);
          long_hold = 1'b0;
        end
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 1)) wait_n = 0;
        if (wait_n > 0) begin
          m_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    trig_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.sine = m_tdata[OUT_W-1:0];
      got.cosine = m_tdata[2*OUT_W-1:OUT_W];
      got.index_err = m_tuser;
      results_seen++;
      if (pending_trig.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h %b", m_tdata, m_tuser);
      end else begin
        want = pending_trig.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sin %0d cos %0d err %b, got sin %0d cos %0d err %b",
                     want.sine, want.cosine, want.index_err,
                     got.sine, got.cosine, got.index_err);
        end
      end
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_SAMPLE_COUNT) period_cfg = data[15:0];
    else if (addr == REG_AMPLITUDE_BITS) amp_cfg = data[4:0];
  endtask

  task automatic configure(logic [15:0] n, logic [4:0] ab);
    reg_write(REG_SAMPLE_COUNT, {16'd0, n});
    reg_write(REG_AMPLITUDE_BITS, {27'd0, ab});
  endtask

  task automatic send_index(logic [15:0] idx, bit gaps, bit known, trig_t result);
    int gap;
    trig_t want;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= idx;
    want = known ? result : sine_cosine(idx);
    do @(posedge clk); while (!s_tready);
    pending_trig.push_back(want);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_trig.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 16'(period_cfg + $urandom_range(0, 3));
      1: return 16'($urandom_range(0, 65535));
      2: return (period_cfg == 0) ? 16'd0 : period_cfg - 1;
      default: return (period_cfg == 0) ? 16'd0 : 16'($urandom_range(0, period_cfg - 1));
    endcase
  endfunction

  row_t directed[] = '{
    '{16'd0,     1'b0, '0},
    '{16'd64,    1'b1, '{24'sd32767, 24'sd0, 1'b0}},
    '{16'd128,   1'b0, '0},
    '{16'd192,   1'b0, '0},
    '{16'd255,   1'b0, '0},
    '{16'd32,    1'b0, '0},
    '{16'd256,   1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{16'd65535, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{16'h5555,  1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{16'hAAAA,  1'b1, '{24'sd0, 24'sd0, 1'b1}}
  };

  initial begin
    logic [15:0] n_list[6] = '{16'd7, 16'd1, 16'd65535, 16'd1000, 16'd3, 16'd360};
    logic [4:0]  a_list[6] = '{5'd24, 5'd0, 5'd31, 5'd1, 5'd2, 5'd12};
    period_cfg = SAMPLE_COUNT_RST;
    amp_cfg = AMPLITUDE_BITS_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_index(directed[i].index, 1'b0, directed[i].known,
                                     directed[i].result);
    drain();
    configure(16'd0, 5'd24);
    send_index(16'd0, 1'b0, 1'b1, '{24'sd0, 24'sd0, 1'b1});
    send_index(16'hFFFF, 1'b0, 1'b1, '{24'sd0, 24'sd0, 1'b1});
    drain();
    configure(16'd65535, 5'd24);
    foreach (n_list[i]) begin end
    send_index(16'd65534, 1'b0, 1'b0, '0);
    send_index(16'd16384, 1'b0, 1'b0, '0);
    send_index(16'd65535, 1'b0, 1'b1, '{24'sd0, 24'sd0, 1'b1});
    drain();

    // long sink hold-off while source keeps pushing
    configure(16'd256, 5'd16);
    long_hold = 1'b1;
    for (int i = 0; i < 150; i++) send_index(pick_index(), 1'b0, 1'b0, '0);
    drain();

    foreach (n_list[p]) begin
      configure(n_list[p], a_list[p]);
      for (int i = 0; i < 160; i++) send_index(pick_index(), 1'b1, 1'b0, '0);
      drain();
    end

    $display("Covered %0d indexes over several period/amplitude settings, %0d results checked.",
             items_sent, results_seen);
    if (mismatches == 0 && pending_trig.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
